// File: src/dqia_pkg.sv
// ----------------------------------------------------------------------------
// dqia_pkg
// Shared types and constants for the indexed double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dqia_pkg;

  localparam int unsigned DEF_CAPACITY = 64;
  localparam int unsigned POS_W        = 6;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CNT_W        = 7;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_READ       = 3'd4,
    ACT_WRITE      = 3'd5,
    ACT_REMOVE     = 3'd6,
    ACT_CLEAR      = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    action_e                   action;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  data_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  data_out;
    status_e                   status;
    logic [CNT_W-1:0]          entry_count;
  } out_beat_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_SHRD = 5'b00100,
    S_SHWR = 5'b01000,
    S_RESP = 5'b10000
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic exec;
    logic shift_rd;
    logic shift_wr;
    logic shift_end;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic shift_req;
    logic more;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: src/dqia_stream_if.sv
// ----------------------------------------------------------------------------
// dqia_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface dqia_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: src/dqia_ctrl.sv
// ----------------------------------------------------------------------------
// dqia_ctrl
// Sequencer: accept, execute, shift loop for remove, response.
// ----------------------------------------------------------------------------
`default_nettype none

module dqia_ctrl
  import dqia_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.shift_req ? S_SHRD : S_RESP;
      end
      S_SHRD: begin
        if (sts_i.more) begin
          cmd_o.shift_rd = 1'b1;
          state_d        = S_SHWR;
        end else begin
          cmd_o.shift_end = 1'b1;
          state_d         = S_RESP;
        end
      end
      S_SHWR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = S_SHRD;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          in_ready_o     = 1'b1;
          if (in_valid_i) begin
            cmd_o.accept = 1'b1;
            state_d      = S_EXEC;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: src/dqia_dpath.sv
// ----------------------------------------------------------------------------
// dqia_dpath
// Ring buffer memory, front/count registers, status logic, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dqia_dpath
  import dqia_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire in_beat_t in_beat_i,
  input  wire dp_cmd_t  cmd_i,
  output dp_sts_t       sts_o,
  output out_beat_t     out_beat_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned OW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (OW > POS_W) ? OW : POS_W;
  localparam int unsigned EW = (OW > CNT_W) ? OW : CNT_W;

  action_e                 act_q;
  logic [POS_W-1:0]        pos_q;
  logic signed [DATA_W-1:0] din_q;
  logic [IW-1:0]           front_q;
  logic [OW-1:0]           occ_q;
  logic [OW-1:0]           k_q;
  status_e                 st_q;
  logic [DATA_W-1:0]       rdata_q;
  logic [DATA_W-1:0]       mem [CAPACITY];
  out_beat_t               out_q;
  logic                    out_valid_q;

  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                            input logic [OW-1:0] off);
    logic [OW:0] sum;
    sum = (OW+1)'(base) + (OW+1)'(off);
    if (sum >= (OW+1)'(CAPACITY)) begin
      sum = sum - (OW+1)'(CAPACITY);
    end
    return sum[IW-1:0];
  endfunction

  logic [OW-1:0]     pos_off, k_inc;
  logic              in_range, empty, full;
  status_e           st_c;
  logic [IW-1:0]     slot_pos, slot_back, slot_next, slot_k, slot_k1, front_dec;
  logic [EW-1:0]     occ_ext;
  logic              we, re;
  logic [IW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata;

  assign pos_off   = OW'(pos_q);
  assign in_range  = CW'(pos_q) < CW'(occ_q);
  assign empty     = (occ_q == '0);
  assign full      = (occ_q == OW'(CAPACITY));
  assign slot_pos  = slot_of(front_q, pos_off);
  assign slot_back = slot_of(front_q, occ_q);
  assign slot_next = slot_of(front_q, OW'(1));
  assign front_dec = (front_q == '0) ? IW'(CAPACITY - 1) : front_q - 1'b1;
  assign k_inc     = k_q + 1'b1;
  assign slot_k    = slot_of(front_q, k_q);
  assign slot_k1   = slot_of(front_q, k_inc);
  assign occ_ext   = EW'(occ_q);

  always_comb begin
    case (act_q)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: st_c = full ? ST_FULL : ST_OK;
      ACT_POP_FRONT, ACT_POP_BACK:   st_c = empty ? ST_EMPTY : ST_OK;
      ACT_READ, ACT_WRITE, ACT_REMOVE: st_c = in_range ? ST_OK : ST_RANGE;
      default:                       st_c = ST_OK;
    endcase
  end

  assign sts_o.shift_req = (act_q == ACT_REMOVE) && in_range && (pos_q != '0);
  assign sts_o.more      = k_inc < occ_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    we    = 1'b0;
    waddr = slot_pos;
    wdata = din_q;
    re    = 1'b0;
    raddr = slot_pos;
    if (cmd_i.exec && st_c == ST_OK) begin
      case (act_q)
        ACT_PUSH_FRONT: begin
          we    = 1'b1;
          waddr = front_dec;
        end
        ACT_PUSH_BACK: begin
          we    = 1'b1;
          waddr = slot_back;
        end
        ACT_WRITE: begin
          we = 1'b1;
        end
        ACT_READ: begin
          re = 1'b1;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
    if (cmd_i.shift_rd) begin
      re    = 1'b1;
      raddr = slot_k1;
    end
    if (cmd_i.shift_wr) begin
      we    = 1'b1;
      waddr = slot_k;
      wdata = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q <= in_beat_i.action;
      pos_q <= in_beat_i.position;
      din_q <= in_beat_i.data_in;
    end
    if (cmd_i.exec) begin
      st_q <= st_c;
      k_q  <= pos_off;
    end
    if (cmd_i.shift_wr) begin
      k_q <= k_inc;
    end
    if (cmd_i.load_out) begin
      out_q.data_out    <= (act_q == ACT_READ && st_q == ST_OK) ? rdata_q : '0;
      out_q.status      <= st_q;
      out_q.entry_count <= occ_ext[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec && st_c == ST_OK) begin
        case (act_q)
          ACT_PUSH_FRONT: begin
            front_q <= front_dec;
            occ_q   <= occ_q + 1'b1;
          end
          ACT_PUSH_BACK: begin
            occ_q <= occ_q + 1'b1;
          end
          ACT_POP_FRONT: begin
            front_q <= slot_next;
            occ_q   <= occ_q - 1'b1;
          end
          ACT_POP_BACK: begin
            occ_q <= occ_q - 1'b1;
          end
          ACT_REMOVE: begin
            if (pos_q == '0) begin
              front_q <= slot_next;
              occ_q   <= occ_q - 1'b1;
            end
          end
          ACT_CLEAR: begin
            front_q <= '0;
            occ_q   <= '0;
          end
          default: begin
            occ_q <= occ_q;
          end
        endcase
      end
      if (cmd_i.shift_end) begin
        occ_q <= occ_q - 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_beat_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: src/deque_with_indexed_access.sv
// ----------------------------------------------------------------------------
// deque_with_indexed_access
// Bounded double-ended queue of signed 32-bit values with indexed access.
//
// in_i carries one command beat: action, position, data_in. Actions push or
// pop at either end, read/write the entry at a position from the front,
// remove an entry (later entries close up) or clear the queue.
// out_o returns one beat per command: data_out, status, entry_count.
// Both channels are valid/ready; a beat moves when both are high.
//
// Each command steps through accept, execute and response; in the response step
// the result is loaded while the next command is accepted. Removing at position
// p > 0 adds a shift loop in which the later entries close up one move at a
// time: each move is one read and one write of the ring buffer memory.
// A stalled receiver holds the output register; the next command is still
// accepted and executed, then waits until the output register frees.
// Reset empties the queue and returns the front pointer to slot zero; the
// memory itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module deque_with_indexed_access
  import dqia_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  dqia_stream_if.sink    in_i,
  dqia_stream_if.source  out_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  dqia_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dqia_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_beat_i   (in_i.payload),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_beat_o  (out_o.payload),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready)
  );

  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> cmd.exec)
    else $error("accepted beat not executed next cycle");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_out && out_o.valid) |-> out_o.ready)
    else $error("output register overwritten while stalled");

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.payload.status != ST_OK) |-> (out_o.payload.data_out == '0))
    else $error("failed command returned nonzero data");

endmodule

`default_nettype wire
